[sv/assert_macros.svh]
// Assertion macros shared by the level control RTL.
// Include once per file; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on the rising clock edge, checked in and out of reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/kalc_pkg.sv]
// Package for the key auto-repeat level control: field widths, codes,
// register defaults and the shared structs. Depends on nothing else.
`default_nettype none

package kalc_pkg;

   localparam int unsigned KEY_W   = 10;
   localparam int unsigned MS_W    = 16;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned LEVEL_W = 6;
   localparam int unsigned CSR_W   = 16;

   // Item kinds on the timeline.
   typedef enum logic [1:0] {
      MODE_FRAME_START = 2'd0,
      MODE_KEY_EVENT   = 2'd1,
      MODE_FRAME_END   = 2'd2
   } mode_type;

   // Key event values that are acted on; the fourth code is ignored.
   typedef enum logic [1:0] {
      KEY_RELEASE = 2'd0,
      KEY_PRESS   = 2'd1,
      KEY_REPEAT  = 2'd2
   } key_value_type;

   localparam logic [4:0] EVENT_KEY = 5'd1;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_MENU_KEY       = 3'd0,
      CSR_PLUS_KEY       = 3'd1,
      CSR_MINUS_KEY      = 3'd2,
      CSR_FIRST_DELAY    = 3'd3,
      CSR_REPEAT_INTERVAL = 3'd4,
      CSR_SLEEP_GAP      = 3'd5,
      CSR_VOLUME_TOP     = 3'd6,
      CSR_BRIGHTNESS_TOP = 3'd7
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [KEY_W-1:0]   MENU_KEY_RESET        = 10'd708;
   localparam logic [KEY_W-1:0]   PLUS_KEY_RESET        = 10'd115;
   localparam logic [KEY_W-1:0]   MINUS_KEY_RESET       = 10'd114;
   localparam logic [MS_W-1:0]    FIRST_DELAY_RESET     = 16'd300;
   localparam logic [MS_W-1:0]    REPEAT_INTERVAL_RESET = 16'd100;
   localparam logic [MS_W-1:0]    SLEEP_GAP_RESET       = 16'd1000;
   localparam logic [LEVEL_W-1:0] VOLUME_TOP_RESET      = 6'd20;
   localparam logic [LEVEL_W-1:0] BRIGHTNESS_TOP_RESET  = 6'd10;

   typedef struct packed {
      logic [KEY_W-1:0]   menu_key_code;
      logic [KEY_W-1:0]   plus_key_code;
      logic [KEY_W-1:0]   minus_key_code;
      logic [MS_W-1:0]    first_delay_ms;
      logic [MS_W-1:0]    repeat_interval_ms;
      logic [MS_W-1:0]    sleep_gap_ms;
      logic [LEVEL_W-1:0] volume_top;
      logic [LEVEL_W-1:0] brightness_top;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] volume;
      logic [LEVEL_W-1:0] brightness;
      logic               volume_changed;
      logic               brightness_changed;
   } result_type;

   // One saturating level step: up stops at the top, down stops at zero.
   function automatic logic [LEVEL_W-1:0] step_level(input logic [LEVEL_W-1:0] lvl,
                                                     input logic [LEVEL_W-1:0] top,
                                                     input logic up);
      logic [LEVEL_W-1:0] res;
      res = lvl;
      if (up) begin
         if (lvl < top) res = lvl + LEVEL_W'(1);
      end else if (lvl != '0) begin
         res = lvl - LEVEL_W'(1);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[sv/key_autorepeat_level_control.sv]
// Top level of the key auto-repeat level control: configuration registers,
// the state core and a two-entry result buffer. Uses kalc_pkg, kalc_core and
// assert_macros.svh.
//
//   Channel  Ports                      Direction  Carries
//   req      req_valid / req_ready      in         one timeline item
//   rsp      rsp_valid / rsp_ready      out        levels and change flags
//   csr      csr_wen / csr_index        in         register write, no read-back
//
// One item per cycle is sustained while the skid register is empty.
// A result is registered for rsp, or in the skid register behind a stall.
// The result register and a skid register hold two results; req_ready is
// low in every cycle in which both are full, whatever rsp_ready does.
// Reset is synchronous: levels and key state clear, registers take defaults.
`default_nettype none
`include "assert_macros.svh"

module key_autorepeat_level_control (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [kalc_pkg::TIME_W-1:0]   req_time_ms,
   input  wire logic [4:0]                    req_event_type,
   input  wire logic [kalc_pkg::KEY_W-1:0]    req_key_code,
   input  wire logic [1:0]                    req_key_value,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [kalc_pkg::LEVEL_W-1:0]  rsp_volume,
   output      logic [kalc_pkg::LEVEL_W-1:0]  rsp_brightness,
   output      logic                          rsp_volume_changed,
   output      logic                          rsp_brightness_changed,
   input  wire logic                          csr_wen,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [kalc_pkg::CSR_W-1:0]    csr_wdata
);

   kalc_pkg::cfg_type    cfg_ff;
   kalc_pkg::result_type new_result;
   kalc_pkg::result_type out_ff, skid_ff;
   logic                 out_valid_ff, skid_valid_ff;
   logic                 accept, pop;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   // Configuration registers; each write keeps the low bits that fit.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.menu_key_code      <= kalc_pkg::MENU_KEY_RESET;
         cfg_ff.plus_key_code      <= kalc_pkg::PLUS_KEY_RESET;
         cfg_ff.minus_key_code     <= kalc_pkg::MINUS_KEY_RESET;
         cfg_ff.first_delay_ms     <= kalc_pkg::FIRST_DELAY_RESET;
         cfg_ff.repeat_interval_ms <= kalc_pkg::REPEAT_INTERVAL_RESET;
         cfg_ff.sleep_gap_ms       <= kalc_pkg::SLEEP_GAP_RESET;
         cfg_ff.volume_top         <= kalc_pkg::VOLUME_TOP_RESET;
         cfg_ff.brightness_top     <= kalc_pkg::BRIGHTNESS_TOP_RESET;
      end else if (csr_wen) begin
         case (kalc_pkg::csr_index_type'(csr_index))
            kalc_pkg::CSR_MENU_KEY:
               cfg_ff.menu_key_code <= csr_wdata[kalc_pkg::KEY_W-1:0];
            kalc_pkg::CSR_PLUS_KEY:
               cfg_ff.plus_key_code <= csr_wdata[kalc_pkg::KEY_W-1:0];
            kalc_pkg::CSR_MINUS_KEY:
               cfg_ff.minus_key_code <= csr_wdata[kalc_pkg::KEY_W-1:0];
            kalc_pkg::CSR_FIRST_DELAY:
               cfg_ff.first_delay_ms <= csr_wdata;
            kalc_pkg::CSR_REPEAT_INTERVAL:
               cfg_ff.repeat_interval_ms <= csr_wdata;
            kalc_pkg::CSR_SLEEP_GAP:
               cfg_ff.sleep_gap_ms <= csr_wdata;
            kalc_pkg::CSR_VOLUME_TOP:
               cfg_ff.volume_top <= csr_wdata[kalc_pkg::LEVEL_W-1:0];
            kalc_pkg::CSR_BRIGHTNESS_TOP:
               cfg_ff.brightness_top <= csr_wdata[kalc_pkg::LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Key state and levels.
   kalc_core u_core (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (accept),
      .item_mode       (req_mode),
      .item_time_ms    (req_time_ms),
      .item_event_type (req_event_type),
      .item_key_code   (req_key_code),
      .item_key_value  (req_key_value),
      .cfg             (cfg_ff),
      .result          (new_result)
   );

   // Result register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) out_ff <= skid_ff;
         else if (accept)   out_ff <= new_result;
      end else if (accept) begin
         skid_ff <= new_result;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_volume             = out_ff.volume;
   assign rsp_brightness         = out_ff.brightness;
   assign rsp_volume_changed     = out_ff.volume_changed;
   assign rsp_brightness_changed = out_ff.brightness_changed;

   // The skid register only fills behind a held result.
   `ASSERT_CLKD(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid register full while result register empty")
   // A stalled result keeps its value.
   `ASSERT_CLKD(a_out_holds, clock, reset, (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_ff)), "stalled result changed")
   // An item accepted while the result is stalled lands in the skid register.
   `ASSERT_CLKD(a_accept_into_skid, clock, reset, (accept && out_valid_ff && !rsp_ready) |=> skid_valid_ff, "accepted item lost behind a stalled result")

endmodule

`default_nettype wire

[sv/kalc_core.sv]
// Key and level state of the level control: frame timing, held and fresh
// flags, repeat due times and the two levels. Uses kalc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kalc_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         item_valid,
   input  wire logic [1:0]                   item_mode,
   input  wire logic [kalc_pkg::TIME_W-1:0]  item_time_ms,
   input  wire logic [4:0]                   item_event_type,
   input  wire logic [kalc_pkg::KEY_W-1:0]   item_key_code,
   input  wire logic [1:0]                   item_key_value,
   input  wire kalc_pkg::cfg_type            cfg,
   output kalc_pkg::result_type              result
);

   logic [kalc_pkg::TIME_W-1:0]  frame_time_ff, frame_time_in;
   logic                         frame_seen_ff, frame_seen_in;
   logic                         discard_ff, discard_in;
   logic                         modifier_held_ff, modifier_held_in;
   logic                         plus_held_ff, plus_held_in;
   logic                         plus_fresh_ff, plus_fresh_in;
   logic [kalc_pkg::TIME_W-1:0]  plus_due_ff, plus_due_in;
   logic                         minus_held_ff, minus_held_in;
   logic                         minus_fresh_ff, minus_fresh_in;
   logic [kalc_pkg::TIME_W-1:0]  minus_due_ff, minus_due_in;
   logic [kalc_pkg::LEVEL_W-1:0] volume_ff, volume_in;
   logic [kalc_pkg::LEVEL_W-1:0] brightness_ff, brightness_in;

   // Frame end working values.
   logic                         mod_eff;
   logic                         p_fresh, p_held, p_go;
   logic                         m_fresh, m_held, m_go;
   logic [kalc_pkg::TIME_W-1:0]  p_due, m_due;
   logic [kalc_pkg::LEVEL_W-1:0] vol_mid, bri_mid;

   // Key event and frame start working values.
   logic                         key_act, key_on;
   logic [kalc_pkg::TIME_W-1:0]  gap, press_due;

   assign gap       = item_time_ms - frame_time_ff;
   assign press_due = frame_time_ff + kalc_pkg::TIME_W'(cfg.first_delay_ms);
   assign key_on    = item_key_value != kalc_pkg::KEY_RELEASE;
   assign key_act   = !discard_ff && (item_event_type == kalc_pkg::EVENT_KEY) &&
                      (item_key_value inside {kalc_pkg::KEY_RELEASE, kalc_pkg::KEY_PRESS,
                                              kalc_pkg::KEY_REPEAT});

   // A discarded frame clears all key state before the keys are served.
   assign mod_eff = !discard_ff && modifier_held_ff;
   assign p_fresh = !discard_ff && plus_fresh_ff;
   assign p_held  = !discard_ff && plus_held_ff;
   assign p_due   = discard_ff ? '0 : plus_due_ff;
   assign m_fresh = !discard_ff && minus_fresh_ff;
   assign m_held  = !discard_ff && minus_held_ff;
   assign m_due   = discard_ff ? '0 : minus_due_ff;
   assign p_go    = p_fresh || (p_held && (frame_time_ff >= p_due));
   assign m_go    = m_fresh || (m_held && (frame_time_ff >= m_due));

   // Plus is served first, minus then works on the level that plus left.
   always_comb begin
      vol_mid = volume_ff;
      bri_mid = brightness_ff;
      if (p_go) begin
         if (mod_eff) bri_mid = kalc_pkg::step_level(brightness_ff, cfg.brightness_top, 1'b1);
         else         vol_mid = kalc_pkg::step_level(volume_ff, cfg.volume_top, 1'b1);
      end
   end

   // Next state for the accepted item.
   always_comb begin
      frame_time_in    = frame_time_ff;
      frame_seen_in    = frame_seen_ff;
      discard_in       = discard_ff;
      modifier_held_in = modifier_held_ff;
      plus_held_in     = plus_held_ff;
      plus_fresh_in    = plus_fresh_ff;
      plus_due_in      = plus_due_ff;
      minus_held_in    = minus_held_ff;
      minus_fresh_in   = minus_fresh_ff;
      minus_due_in     = minus_due_ff;
      volume_in        = volume_ff;
      brightness_in    = brightness_ff;
      case (kalc_pkg::mode_type'(item_mode))
         kalc_pkg::MODE_FRAME_START: begin
            discard_in    = frame_seen_ff && (gap > kalc_pkg::TIME_W'(cfg.sleep_gap_ms));
            frame_time_in = item_time_ms;
            frame_seen_in = 1'b1;
         end
         kalc_pkg::MODE_KEY_EVENT: begin
            if (key_act) begin
               if (item_key_code == cfg.menu_key_code) modifier_held_in = key_on;
               if (item_key_code == cfg.plus_key_code) begin
                  plus_held_in  = key_on;
                  plus_fresh_in = key_on;
                  if (key_on) plus_due_in = press_due;
               end
               if (item_key_code == cfg.minus_key_code) begin
                  minus_held_in  = key_on;
                  minus_fresh_in = key_on;
                  if (key_on) minus_due_in = press_due;
               end
            end
         end
         kalc_pkg::MODE_FRAME_END: begin
            modifier_held_in = mod_eff;
            plus_held_in     = p_held;
            plus_fresh_in    = 1'b0;
            plus_due_in      = (p_go && !p_fresh) ?
                               p_due + kalc_pkg::TIME_W'(cfg.repeat_interval_ms) : p_due;
            minus_held_in    = m_held;
            minus_fresh_in   = 1'b0;
            minus_due_in     = (m_go && !m_fresh) ?
                               m_due + kalc_pkg::TIME_W'(cfg.repeat_interval_ms) : m_due;
            volume_in        = vol_mid;
            brightness_in    = bri_mid;
            if (m_go) begin
               if (mod_eff) brightness_in = kalc_pkg::step_level(bri_mid, cfg.brightness_top, 1'b0);
               else         volume_in     = kalc_pkg::step_level(vol_mid, cfg.volume_top, 1'b0);
            end
            discard_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Result of the accepted item, taken by the output stage in the same cycle.
   assign result.volume             = volume_in;
   assign result.brightness         = brightness_in;
   assign result.volume_changed     = volume_in != volume_ff;
   assign result.brightness_changed = brightness_in != brightness_ff;

   // State registers, updated once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff    <= '0;
         frame_seen_ff    <= 1'b0;
         discard_ff       <= 1'b0;
         modifier_held_ff <= 1'b0;
         plus_held_ff     <= 1'b0;
         plus_fresh_ff    <= 1'b0;
         plus_due_ff      <= '0;
         minus_held_ff    <= 1'b0;
         minus_fresh_ff   <= 1'b0;
         minus_due_ff     <= '0;
         volume_ff        <= '0;
         brightness_ff    <= '0;
      end else if (item_valid) begin
         frame_time_ff    <= frame_time_in;
         frame_seen_ff    <= frame_seen_in;
         discard_ff       <= discard_in;
         modifier_held_ff <= modifier_held_in;
         plus_held_ff     <= plus_held_in;
         plus_fresh_ff    <= plus_fresh_in;
         plus_due_ff      <= plus_due_in;
         minus_held_ff    <= minus_held_in;
         minus_fresh_ff   <= minus_fresh_in;
         minus_due_ff     <= minus_due_in;
         volume_ff        <= volume_in;
         brightness_ff    <= brightness_in;
      end
   end

   // A frame end leaves no fresh key and no discard mark behind.
   `ASSERT_CLKD(a_frame_end_clears, clock, reset, (item_valid && item_mode == kalc_pkg::MODE_FRAME_END) |=> (!plus_fresh_ff && !minus_fresh_ff && !discard_ff), "frame end left fresh or discard state")
   // A discarded frame ignores its key events.
   `ASSERT_CLKD(a_discard_ignores_keys, clock, reset, (item_valid && discard_ff && item_mode == kalc_pkg::MODE_KEY_EVENT) |=> ($stable(plus_held_ff) && $stable(minus_held_ff) && $stable(modifier_held_ff)), "key event acted on in a discarded frame")

endmodule

`default_nettype wire

[tb/key_autorepeat_level_control_test.sv]
// Self-checking testbench for key_autorepeat_level_control: a directed table, then
// randomised frames of key events under several register settings and idling mixes.
// Depends on kalc_pkg and the key_autorepeat_level_control RTL only.

module key_autorepeat_level_control_test;

   // Codes with no member in the package enums.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] KEY_IGNORED = 2'd3;
   localparam logic [4:0] EVENT_OTHER = 5'd0;

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 140;

   // One timeline item as it is driven on the request ports.
   typedef struct packed {
      logic [1:0]                  mode;
      logic [kalc_pkg::TIME_W-1:0] time_ms;
      logic [4:0]                  event_type;
      logic [kalc_pkg::KEY_W-1:0]  key_code;
      logic [1:0]                  key_value;
   } timeline_item_type;

   // A stimulus row: the item and, where it is plain to see, the levels it must give.
   typedef struct packed {
      timeline_item_type    it;
      logic                 typed;
      kalc_pkg::result_type want;
   } keypad_row_type;

   // Everything the level control remembers between items.
   typedef struct packed {
      logic [kalc_pkg::TIME_W-1:0]  frame_time;
      logic                         frame_seen;
      logic                         discard;
      logic                         modifier;
      logic                         plus_held;
      logic                         plus_fresh;
      logic                         minus_held;
      logic                         minus_fresh;
      logic [kalc_pkg::TIME_W-1:0]  plus_due;
      logic [kalc_pkg::TIME_W-1:0]  minus_due;
      logic [kalc_pkg::LEVEL_W-1:0] volume;
      logic [kalc_pkg::LEVEL_W-1:0] brightness;
   } keypad_state_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [1:0]                   req_mode = 2'd0;
   logic [kalc_pkg::TIME_W-1:0]  req_time_ms = '0;
   logic [4:0]                   req_event_type = '0;
   logic [kalc_pkg::KEY_W-1:0]   req_key_code = '0;
   logic [1:0]                   req_key_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [kalc_pkg::LEVEL_W-1:0] rsp_volume;
   logic [kalc_pkg::LEVEL_W-1:0] rsp_brightness;
   logic                         rsp_volume_changed;
   logic                         rsp_brightness_changed;
   logic                         csr_wen = 1'b0;
   logic [2:0]                   csr_index = '0;
   logic [kalc_pkg::CSR_W-1:0]   csr_wdata = '0;

   keypad_state_type             keypad;
   kalc_pkg::cfg_type            cfg_model;
   kalc_pkg::result_type         level_expect_q[$];
   keypad_row_type               pending_rows_q[$];
   keypad_row_type               directed_rows[$];
   int                           sender_idle_pct = 0;
   int                           receiver_stall_pct = 0;
   int                           items_sent = 0;
   int                           results_seen = 0;
   int                           fail_count = 0;
   logic [kalc_pkg::TIME_W-1:0]  frame_clock = '0;

   key_autorepeat_level_control i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (req_mode),
      .req_time_ms            (req_time_ms),
      .req_event_type         (req_event_type),
      .req_key_code           (req_key_code),
      .req_key_value          (req_key_value),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_volume             (rsp_volume),
      .rsp_brightness         (rsp_brightness),
      .rsp_volume_changed     (rsp_volume_changed),
      .rsp_brightness_changed (rsp_brightness_changed),
      .csr_wen                (csr_wen),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   // The clock runs with a period of 12 units.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Prints one line for a mismatch and counts it.
   task automatic report_mismatch(input string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      fail_count++;
   endtask

   // One level step, up to the selected top or down to zero.
   function automatic void nudge_level(input logic up);
      logic [kalc_pkg::LEVEL_W-1:0] lvl;
      logic [kalc_pkg::LEVEL_W-1:0] top;
      lvl = keypad.modifier ? keypad.brightness : keypad.volume;
      top = keypad.modifier ? cfg_model.brightness_top : cfg_model.volume_top;
      if (up && lvl < top) begin
         lvl = lvl + 6'd1;
      end else if (!up && lvl != 6'd0) begin
         lvl = lvl - 6'd1;
      end
      if (keypad.modifier) begin
         keypad.brightness = lvl;
      end else begin
         keypad.volume = lvl;
      end
   endfunction

   // A fresh key steps once; a held key steps each time its due time is reached.
   function automatic void serve_key(input logic up);
      logic                        held;
      logic                        fresh;
      logic [kalc_pkg::TIME_W-1:0] due;
      held  = up ? keypad.plus_held  : keypad.minus_held;
      fresh = up ? keypad.plus_fresh : keypad.minus_fresh;
      due   = up ? keypad.plus_due   : keypad.minus_due;
      if (fresh || (held && keypad.frame_time >= due)) begin
         nudge_level(up);
         if (fresh) begin
            fresh = 1'b0;
         end else begin
            due = due + kalc_pkg::TIME_W'(cfg_model.repeat_interval_ms);
         end
      end
      if (up) begin
         keypad.plus_fresh = fresh;
         keypad.plus_due   = due;
      end else begin
         keypad.minus_fresh = fresh;
         keypad.minus_due   = due;
      end
   endfunction

   // Applies one item to the predicted state and returns the levels it reports.
   function automatic kalc_pkg::result_type advance_levels(input timeline_item_type it);
      logic [kalc_pkg::LEVEL_W-1:0] vol0;
      logic [kalc_pkg::LEVEL_W-1:0] bri0;
      logic                         on;
      kalc_pkg::result_type         res;
      vol0 = keypad.volume;
      bri0 = keypad.brightness;
      case (it.mode)
         kalc_pkg::MODE_FRAME_START: begin
            keypad.discard    = keypad.frame_seen &&
                                (kalc_pkg::TIME_W'(it.time_ms - keypad.frame_time) >
                                 kalc_pkg::TIME_W'(cfg_model.sleep_gap_ms));
            keypad.frame_time = it.time_ms;
            keypad.frame_seen = 1'b1;
         end
         kalc_pkg::MODE_KEY_EVENT: begin
            if (!keypad.discard && it.event_type == kalc_pkg::EVENT_KEY &&
                it.key_value != KEY_IGNORED) begin
               on = (it.key_value != kalc_pkg::KEY_RELEASE);
               if (it.key_code == cfg_model.menu_key_code) keypad.modifier = on;
               if (it.key_code == cfg_model.plus_key_code) begin
                  keypad.plus_held  = on;
                  keypad.plus_fresh = on;
                  if (on) keypad.plus_due = keypad.frame_time +
                                            kalc_pkg::TIME_W'(cfg_model.first_delay_ms);
               end
               if (it.key_code == cfg_model.minus_key_code) begin
                  keypad.minus_held  = on;
                  keypad.minus_fresh = on;
                  if (on) keypad.minus_due = keypad.frame_time +
                                             kalc_pkg::TIME_W'(cfg_model.first_delay_ms);
               end
            end
         end
         kalc_pkg::MODE_FRAME_END: begin
            // A discarded frame forgets every key before the keys are served.
            if (keypad.discard) begin
               keypad.modifier    = 1'b0;
               keypad.plus_held   = 1'b0;
               keypad.plus_fresh  = 1'b0;
               keypad.minus_held  = 1'b0;
               keypad.minus_fresh = 1'b0;
               keypad.plus_due    = '0;
               keypad.minus_due   = '0;
            end
            serve_key(1'b1);
            serve_key(1'b0);
            keypad.discard = 1'b0;
         end
         default: begin
         end
      endcase
      res.volume             = keypad.volume;
      res.brightness         = keypad.brightness;
      res.volume_changed     = (keypad.volume != vol0);
      res.brightness_changed = (keypad.brightness != bri0);
      return res;
   endfunction

   // Watches both channels and the register port at every edge; the result side is
   // handled before the item side so that the order within a step never matters.
   always @(posedge clock) begin : watch_ports
      kalc_pkg::result_type seen;
      kalc_pkg::result_type want;
      keypad_row_type       row;
      timeline_item_type    arrived;
      if (reset) begin
         keypad    = '0;
         cfg_model = '{kalc_pkg::MENU_KEY_RESET, kalc_pkg::PLUS_KEY_RESET,
                       kalc_pkg::MINUS_KEY_RESET, kalc_pkg::FIRST_DELAY_RESET,
                       kalc_pkg::REPEAT_INTERVAL_RESET, kalc_pkg::SLEEP_GAP_RESET,
                       kalc_pkg::VOLUME_TOP_RESET, kalc_pkg::BRIGHTNESS_TOP_RESET};
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_volume, rsp_brightness, rsp_volume_changed, rsp_brightness_changed};
            if (level_expect_q.size() == 0) begin
               report_mismatch("result arrived with nothing expected");
            end else begin
               want = level_expect_q.pop_front();
               if (seen.volume !== want.volume)
                  report_mismatch($sformatf("volume %0d, expected %0d",
                                            seen.volume, want.volume));
               if (seen.brightness !== want.brightness)
                  report_mismatch($sformatf("brightness %0d, expected %0d",
                                            seen.brightness, want.brightness));
               if (seen.volume_changed !== want.volume_changed)
                  report_mismatch($sformatf("volume_changed %0b, expected %0b",
                                            seen.volume_changed, want.volume_changed));
               if (seen.brightness_changed !== want.brightness_changed)
                  report_mismatch($sformatf("brightness_changed %0b, expected %0b",
                                            seen.brightness_changed, want.brightness_changed));
            end
            results_seen++;
         end
         if (req_valid && req_ready) begin
            arrived = '{req_mode, req_time_ms, req_event_type, req_key_code, req_key_value};
            want    = advance_levels(arrived);
            if (pending_rows_q.size() != 0) begin
               row = pending_rows_q.pop_front();
               if (row.typed) want = row.want;
            end
            level_expect_q.push_back(want);
         end
         if (csr_wen) begin
            case (csr_index)
               kalc_pkg::CSR_MENU_KEY:
                  cfg_model.menu_key_code = csr_wdata[kalc_pkg::KEY_W-1:0];
               kalc_pkg::CSR_PLUS_KEY:
                  cfg_model.plus_key_code = csr_wdata[kalc_pkg::KEY_W-1:0];
               kalc_pkg::CSR_MINUS_KEY:
                  cfg_model.minus_key_code = csr_wdata[kalc_pkg::KEY_W-1:0];
               kalc_pkg::CSR_FIRST_DELAY:
                  cfg_model.first_delay_ms = csr_wdata[kalc_pkg::MS_W-1:0];
               kalc_pkg::CSR_REPEAT_INTERVAL:
                  cfg_model.repeat_interval_ms = csr_wdata[kalc_pkg::MS_W-1:0];
               kalc_pkg::CSR_SLEEP_GAP:
                  cfg_model.sleep_gap_ms = csr_wdata[kalc_pkg::MS_W-1:0];
               kalc_pkg::CSR_VOLUME_TOP:
                  cfg_model.volume_top = csr_wdata[kalc_pkg::LEVEL_W-1:0];
               kalc_pkg::CSR_BRIGHTNESS_TOP:
                  cfg_model.brightness_top = csr_wdata[kalc_pkg::LEVEL_W-1:0];
               default: begin
               end
            endcase
         end
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // A row that is checked against the predictor only.
   function automatic keypad_row_type model_row(input logic [1:0] m,
                                                input logic [kalc_pkg::TIME_W-1:0] t,
                                                input logic [4:0] e,
                                                input logic [kalc_pkg::KEY_W-1:0] c,
                                                input logic [1:0] v);
      keypad_row_type r;
      r.it    = '{m, t, e, c, v};
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   // A row whose levels are written out in the table.
   function automatic keypad_row_type typed_row(input logic [1:0] m,
                                                input logic [kalc_pkg::TIME_W-1:0] t,
                                                input logic [4:0] e,
                                                input logic [kalc_pkg::KEY_W-1:0] c,
                                                input logic [1:0] v,
                                                input logic [kalc_pkg::LEVEL_W-1:0] vol,
                                                input logic [kalc_pkg::LEVEL_W-1:0] bri,
                                                input logic vc,
                                                input logic bc);
      keypad_row_type r;
      r       = model_row(m, t, e, c, v);
      r.typed = 1'b1;
      r.want  = '{vol, bri, vc, bc};
      return r;
   endfunction

   // Any item at all, every field drawn over its full range.
   function automatic timeline_item_type scrambled_item();
      timeline_item_type it;
      it.mode       = 2'($urandom_range(0, 3));
      it.time_ms    = $urandom;
      it.event_type = 5'($urandom_range(0, 31));
      it.key_code   = 10'($urandom_range(0, 1023));
      it.key_value  = 2'($urandom_range(0, 3));
      return it;
   endfunction

   // Register settings for each phase: defaults, the two extremes, then random ones.
   function automatic kalc_pkg::cfg_type settings_for(input int phase);
      kalc_pkg::cfg_type c;
      case (phase)
         0: c = '{kalc_pkg::MENU_KEY_RESET, kalc_pkg::PLUS_KEY_RESET,
                  kalc_pkg::MINUS_KEY_RESET, kalc_pkg::FIRST_DELAY_RESET,
                  kalc_pkg::REPEAT_INTERVAL_RESET, kalc_pkg::SLEEP_GAP_RESET,
                  kalc_pkg::VOLUME_TOP_RESET, kalc_pkg::BRIGHTNESS_TOP_RESET};
         1: c = '{10'd0, 10'd1023, 10'd512, 16'd0, 16'd1, 16'hFFFF, 6'd1, 6'd63};
         2: c = '{10'd1023, 10'd0, 10'd0, 16'hFFFF, 16'hFFFF, 16'd0, 6'd63, 6'd1};
         default: begin
            // Small code ranges make shared codes likely; phase four lowers the tops
            // beneath levels that earlier phases may have reached.
            c.menu_key_code      = 10'($urandom_range(0, phase == 5 ? 1023 : 3));
            c.plus_key_code      = 10'($urandom_range(0, phase == 5 ? 1023 : 3));
            c.minus_key_code     = 10'($urandom_range(0, phase == 5 ? 1023 : 3));
            c.first_delay_ms     = 16'($urandom_range(0, 500));
            c.repeat_interval_ms = 16'($urandom_range(1, phase == 5 ? 65535 : 200));
            c.sleep_gap_ms       = 16'($urandom_range(0, phase == 5 ? 65535 : 1500));
            c.volume_top         = 6'($urandom_range(1, phase == 4 ? 3 : 63));
            c.brightness_top     = 6'($urandom_range(1, phase == 4 ? 3 : 63));
         end
      endcase
      return c;
   endfunction

   // Writes one register; the write lands at the next rising edge.
   task automatic poke(input kalc_pkg::csr_index_type idx,
                       input logic [kalc_pkg::CSR_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_settings(input kalc_pkg::cfg_type c);
      poke(kalc_pkg::CSR_MENU_KEY,        kalc_pkg::CSR_W'(c.menu_key_code));
      poke(kalc_pkg::CSR_PLUS_KEY,        kalc_pkg::CSR_W'(c.plus_key_code));
      poke(kalc_pkg::CSR_MINUS_KEY,       kalc_pkg::CSR_W'(c.minus_key_code));
      poke(kalc_pkg::CSR_FIRST_DELAY,     c.first_delay_ms);
      poke(kalc_pkg::CSR_REPEAT_INTERVAL, c.repeat_interval_ms);
      poke(kalc_pkg::CSR_SLEEP_GAP,       c.sleep_gap_ms);
      poke(kalc_pkg::CSR_VOLUME_TOP,      kalc_pkg::CSR_W'(c.volume_top));
      poke(kalc_pkg::CSR_BRIGHTNESS_TOP,  kalc_pkg::CSR_W'(c.brightness_top));
      csr_wen <= 1'b0;
   endtask

   // Presents one item, after an optional gap, and holds it until it is taken.
   task automatic send_item(input keypad_row_type r);
      // Each cycle before the item the sender stays idle with the set chance.
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= r.it.mode;
      req_time_ms    <= r.it.time_ms;
      req_event_type <= r.it.event_type;
      req_key_code   <= r.it.key_code;
      req_key_value  <= r.it.key_value;
      pending_rows_q.push_back(r);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Sends an item that is checked against the predictor only.
   task automatic send_plain(input timeline_item_type it);
      keypad_row_type r;
      r.it    = it;
      r.typed = 1'b0;
      r.want  = '0;
      send_item(r);
   endtask

   // A well-formed frame with random content; now and then the frame end is left out.
   task automatic send_frame(input kalc_pkg::cfg_type plan);
      timeline_item_type           it;
      logic [kalc_pkg::TIME_W-1:0] step;
      case ($urandom_range(0, 9))
         0: step = '0;
         1: step = $urandom;
         2: step = kalc_pkg::TIME_W'(plan.sleep_gap_ms) +
                   kalc_pkg::TIME_W'($urandom_range(1, 40));
         3: step = kalc_pkg::TIME_W'(plan.sleep_gap_ms);
         default: step = kalc_pkg::TIME_W'($urandom_range(1, 250));
      endcase
      frame_clock = frame_clock + step;
      it         = scrambled_item();
      it.mode    = kalc_pkg::MODE_FRAME_START;
      it.time_ms = frame_clock;
      send_plain(it);
      repeat ($urandom_range(0, 4)) begin
         it      = scrambled_item();
         it.mode = kalc_pkg::MODE_KEY_EVENT;
         if ($urandom_range(0, 9) != 0) it.event_type = kalc_pkg::EVENT_KEY;
         case ($urandom_range(0, 3))
            0: it.key_code = plan.menu_key_code;
            1: it.key_code = plan.plus_key_code;
            2: it.key_code = plan.minus_key_code;
            default: begin
            end
         endcase
         it.key_value = ($urandom_range(0, 9) == 0) ? KEY_IGNORED : 2'($urandom_range(0, 2));
         send_plain(it);
      end
      if ($urandom_range(0, 9) != 0) begin
         it      = scrambled_item();
         it.mode = kalc_pkg::MODE_FRAME_END;
         send_plain(it);
      end
   endtask

   // Main sequence: reset, then six phases of settings, idling and items.
   initial begin : stimulus
      kalc_pkg::cfg_type plan;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table, read against the register defaults.
      directed_rows.push_back(typed_row(MODE_UNUSED, '0, EVENT_OTHER, 10'd0,
                                        kalc_pkg::KEY_RELEASE, 6'd0, 6'd0, 1'b0, 1'b0));
      directed_rows.push_back(typed_row(MODE_UNUSED, 32'hFFFF_FFFF, 5'h1F, 10'h3FF,
                                        KEY_IGNORED, 6'd0, 6'd0, 1'b0, 1'b0));
      // Frame end and key events before any frame start use frame time zero.
      directed_rows.push_back(typed_row(kalc_pkg::MODE_FRAME_END, '0, EVENT_OTHER, 10'd0,
                                        kalc_pkg::KEY_RELEASE, 6'd0, 6'd0, 1'b0, 1'b0));
      directed_rows.push_back(typed_row(kalc_pkg::MODE_KEY_EVENT, '0, kalc_pkg::EVENT_KEY,
                                        kalc_pkg::MINUS_KEY_RESET, kalc_pkg::KEY_PRESS,
                                        6'd0, 6'd0, 1'b0, 1'b0));
      // A step down at level zero holds the level.
      directed_rows.push_back(typed_row(kalc_pkg::MODE_FRAME_END, '0, EVENT_OTHER, 10'd0,
                                        kalc_pkg::KEY_RELEASE, 6'd0, 6'd0, 1'b0, 1'b0));
      directed_rows.push_back(typed_row(kalc_pkg::MODE_KEY_EVENT, '0, kalc_pkg::EVENT_KEY,
                                        kalc_pkg::MINUS_KEY_RESET, kalc_pkg::KEY_RELEASE,
                                        6'd0, 6'd0, 1'b0, 1'b0));
      directed_rows.push_back(typed_row(kalc_pkg::MODE_KEY_EVENT, '0, kalc_pkg::EVENT_KEY,
                                        kalc_pkg::PLUS_KEY_RESET, kalc_pkg::KEY_PRESS,
                                        6'd0, 6'd0, 1'b0, 1'b0));
      directed_rows.push_back(typed_row(kalc_pkg::MODE_FRAME_END, '0, EVENT_OTHER, 10'd0,
                                        kalc_pkg::KEY_RELEASE, 6'd1, 6'd0, 1'b1, 1'b0));
      // The first frame never discards; the next start wraps round past zero.
      directed_rows.push_back(model_row(kalc_pkg::MODE_FRAME_START, 32'hFFFF_FFF0,
                                        EVENT_OTHER, 10'd0, kalc_pkg::KEY_RELEASE));
      directed_rows.push_back(model_row(kalc_pkg::MODE_FRAME_START, 32'h0000_0100,
                                        EVENT_OTHER, 10'd0, kalc_pkg::KEY_RELEASE));
      directed_rows.push_back(model_row(kalc_pkg::MODE_FRAME_END, '0, EVENT_OTHER, 10'd0,
                                        kalc_pkg::KEY_RELEASE));
      directed_rows.push_back(model_row(kalc_pkg::MODE_FRAME_START, 32'd400, EVENT_OTHER,
                                        10'd0, kalc_pkg::KEY_RELEASE));
      directed_rows.push_back(model_row(kalc_pkg::MODE_FRAME_END, '0, EVENT_OTHER, 10'd0,
                                        kalc_pkg::KEY_RELEASE));
      // Menu held, plus due and minus fresh: the two steps cancel.
      directed_rows.push_back(model_row(kalc_pkg::MODE_KEY_EVENT, '0, kalc_pkg::EVENT_KEY,
                                        kalc_pkg::MENU_KEY_RESET, kalc_pkg::KEY_REPEAT));
      directed_rows.push_back(model_row(kalc_pkg::MODE_KEY_EVENT, '0, kalc_pkg::EVENT_KEY,
                                        kalc_pkg::MINUS_KEY_RESET, kalc_pkg::KEY_PRESS));
      directed_rows.push_back(model_row(kalc_pkg::MODE_FRAME_END, '0, EVENT_OTHER, 10'd0,
                                        kalc_pkg::KEY_RELEASE));
      // Events that are not key events, and the ignored key value.
      directed_rows.push_back(model_row(kalc_pkg::MODE_KEY_EVENT, '0, 5'h1F,
                                        kalc_pkg::PLUS_KEY_RESET, kalc_pkg::KEY_RELEASE));
      directed_rows.push_back(model_row(kalc_pkg::MODE_KEY_EVENT, '0, kalc_pkg::EVENT_KEY,
                                        kalc_pkg::PLUS_KEY_RESET, KEY_IGNORED));
      // A long gap discards the frame, and its end clears every key.
      directed_rows.push_back(model_row(kalc_pkg::MODE_FRAME_START, 32'd5000, EVENT_OTHER,
                                        10'd0, kalc_pkg::KEY_RELEASE));
      directed_rows.push_back(model_row(kalc_pkg::MODE_KEY_EVENT, '0, kalc_pkg::EVENT_KEY,
                                        kalc_pkg::PLUS_KEY_RESET, kalc_pkg::KEY_RELEASE));
      directed_rows.push_back(model_row(kalc_pkg::MODE_FRAME_END, '0, EVENT_OTHER, 10'd0,
                                        kalc_pkg::KEY_RELEASE));
      directed_rows.push_back(model_row(kalc_pkg::MODE_FRAME_START, 32'd5001, EVENT_OTHER,
                                        10'd0, kalc_pkg::KEY_RELEASE));
      directed_rows.push_back(model_row(kalc_pkg::MODE_KEY_EVENT, '0, EVENT_OTHER, 10'd0,
                                        kalc_pkg::KEY_PRESS));
      directed_rows.push_back(model_row(kalc_pkg::MODE_FRAME_END, '0, EVENT_OTHER, 10'd0,
                                        kalc_pkg::KEY_RELEASE));

      for (int phase = 0; phase < PHASES; phase++) begin
         sender_idle_pct    = (phase < 2) ? 21 : (phase < 4) ? 63 : 0;
         receiver_stall_pct = (phase < 2) ? 63 : (phase < 4) ? 21 : 0;
         plan = settings_for(phase);
         write_settings(plan);
         if (phase == 0) begin
            foreach (directed_rows[i]) send_item(directed_rows[i]);
            frame_clock = 32'd5001;
         end
         // Mostly whole frames; the rest is loose items of any kind.
         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 85) begin
               send_frame(plan);
            end else begin
               send_plain(scrambled_item());
            end
         end
         req_valid <= 1'b0;
         // Registers change only once every result of the phase has come back.
         do @(posedge clock); while (level_expect_q.size() != 0);
      end

      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("** key_autorepeat_level_control: PASSED **");
      end else begin
         $display("** key_autorepeat_level_control: FAILED **");
      end
      $finish;
   end

   // Ends a run that hangs.
   initial begin : watchdog
      #2400000;
      $display("** key_autorepeat_level_control: FAILED **");
      $finish;
   end

endmodule

[key_autorepeat_level_control.f]
+incdir+sv
sv/kalc_pkg.sv
sv/kalc_core.sv
sv/key_autorepeat_level_control.sv
tb/key_autorepeat_level_control_test.sv
